// ===== rtl/core/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int CoordW  = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int CrossW  = ProdW + 1;
  localparam int SumW    = CrossW + 1;
  localparam int CfgIdxW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_INSIDE = 2'd0,
    OUT_BOX    = 2'd1,
    OUT_BARY   = 2'd2,
    OUT_DEGEN  = 2'd3
  } outcome_e;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } tri_t;

  // edge vectors and query offset relative to vertex a, with the box test flag
  typedef struct packed {
    logic  out_box;
    diff_t v0x;
    diff_t v0y;
    diff_t v1x;
    diff_t v1y;
    diff_t v2x;
    diff_t v2y;
  } prep_t;

  typedef struct packed {
    logic  out_box;
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
    prod_t p4;
    prod_t p5;
  } prod_stage_t;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

// ===== rtl/core/ptt_prep.sv =====
`timescale 1ns / 1ps

module ptt_prep import ptt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  tri_t   tri_i,
  input  coord_t query_x_i,
  input  coord_t query_y_i,
  output logic   valid_o,
  output prep_t  prep_o
);

  logic  valid_q;
  prep_t prep_d, prep_q;

  always_comb begin
    prep_d.out_box = (query_x_i < min3(tri_i.ax, tri_i.bx, tri_i.cx)) ||
                     (query_x_i > max3(tri_i.ax, tri_i.bx, tri_i.cx)) ||
                     (query_y_i < min3(tri_i.ay, tri_i.by, tri_i.cy)) ||
                     (query_y_i > max3(tri_i.ay, tri_i.by, tri_i.cy));
    prep_d.v0x = diff_t'(tri_i.cx) - diff_t'(tri_i.ax);
    prep_d.v0y = diff_t'(tri_i.cy) - diff_t'(tri_i.ay);
    prep_d.v1x = diff_t'(tri_i.bx) - diff_t'(tri_i.ax);
    prep_d.v1y = diff_t'(tri_i.by) - diff_t'(tri_i.ay);
    prep_d.v2x = diff_t'(query_x_i) - diff_t'(tri_i.ax);
    prep_d.v2y = diff_t'(query_y_i) - diff_t'(tri_i.ay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

// ===== rtl/core/ptt_mul.sv =====
`timescale 1ns / 1ps

module ptt_mul import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  prep_t       prep_i,
  output logic        valid_o,
  output prod_stage_t prod_o
);

  logic        valid_q;
  prod_stage_t prod_d, prod_q;
  diff_t       v0x, v0y, v1x, v1y, v2x, v2y;

  always_comb begin
    v0x = prep_i.v0x;
    v0y = prep_i.v0y;
    v1x = prep_i.v1x;
    v1y = prep_i.v1y;
    v2x = prep_i.v2x;
    v2y = prep_i.v2y;
    prod_d.out_box = prep_i.out_box;
    prod_d.p0 = prod_t'(v0x) * prod_t'(v1y);
    prod_d.p1 = prod_t'(v0y) * prod_t'(v1x);
    prod_d.p2 = prod_t'(v2x) * prod_t'(v1y);
    prod_d.p3 = prod_t'(v2y) * prod_t'(v1x);
    prod_d.p4 = prod_t'(v0x) * prod_t'(v2y);
    prod_d.p5 = prod_t'(v0y) * prod_t'(v2x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== rtl/core/ptt_decide.sv =====
`timescale 1ns / 1ps

module ptt_decide import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  prod_stage_t prod_i,
  output logic        valid_o,
  output logic        inside_o,
  output outcome_e    outcome_o
);

  // cross products
  logic     x_valid_q;
  logic     x_box_q;
  cross_t   x_d_d, x_w_d, x_t_d;
  cross_t   x_d_q, x_w_q, x_t_q;

  // sign normalized
  logic     n_valid_q;
  logic     n_box_q, n_zero_q;
  cross_t   n_d_d, n_w_d, n_t_d;
  cross_t   n_d_q, n_w_q, n_t_q;

  // result
  logic     r_valid_q;
  logic     r_inside_d, r_inside_q;
  outcome_e r_code_d, r_code_q;
  sum_t     wt_sum;

  always_comb begin
    x_d_d = cross_t'(prod_i.p0) - cross_t'(prod_i.p1);
    x_w_d = cross_t'(prod_i.p2) - cross_t'(prod_i.p3);
    x_t_d = cross_t'(prod_i.p4) - cross_t'(prod_i.p5);
  end

  always_comb begin
    if (x_d_q < 0) begin
      n_d_d = -x_d_q;
      n_w_d = -x_w_q;
      n_t_d = -x_t_q;
    end else begin
      n_d_d = x_d_q;
      n_w_d = x_w_q;
      n_t_d = x_t_q;
    end
  end

  always_comb begin
    wt_sum = sum_t'(n_w_q) + sum_t'(n_t_q);
    r_inside_d = 1'b0;
    priority if (n_box_q) begin
      r_code_d = OUT_BOX;
    end else if (n_zero_q) begin
      r_code_d = OUT_DEGEN;
    end else if ((n_w_q < 0) || (n_w_q > n_d_q) || (n_t_q < 0) || (n_t_q > n_d_q) ||
                 (wt_sum > sum_t'(n_d_q))) begin
      r_code_d = OUT_BARY;
    end else begin
      r_code_d   = OUT_INSIDE;
      r_inside_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      n_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      x_valid_q <= valid_i;
      n_valid_q <= x_valid_q;
      r_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_box_q    <= prod_i.out_box;
    x_d_q      <= x_d_d;
    x_w_q      <= x_w_d;
    x_t_q      <= x_t_d;
    n_box_q    <= x_box_q;
    n_zero_q   <= (x_d_q == '0);
    n_d_q      <= n_d_d;
    n_w_q      <= n_w_d;
    n_t_q      <= n_t_d;
    r_inside_q <= r_inside_d;
    r_code_q   <= r_code_d;
  end

  assign valid_o   = r_valid_q;
  assign inside_o  = r_inside_q;
  assign outcome_o = r_code_q;

endmodule

// ===== rtl/core/point_in_triangle_test.sv =====
`timescale 1ns / 1ps

// Point-in-triangle test for signed grid coordinates.
// Triangle vertices are written through the config channel (cfg_valid_i /
// cfg_ready_o, cfg_index_i selects a_x, a_y, b_x, b_y, c_x, c_y as 0..5,
// other indexes are dropped). cfg_ready_o is always high; write only while
// no query is in flight.
// A query beat is taken on any edge with start_i high and busy_o low;
// busy_o stays low, so one point can enter every cycle.
// Each query gives one result: done_o is high for one cycle, with
// inside_res_o and outcome_o (inside, outside box, outside barycentric,
// degenerate triangle).
// There are five register stages: box test and edge vectors, 17x17
// products, cross products, sign fold, final compares.
// Throughput is one point per cycle.
// The receiver cannot stall; results appear on schedule and must be taken.
// Reset clears all vertices to zero and drops every query in flight.

module point_in_triangle_test import ptt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [CoordW-1:0]  query_x_i,
  input  logic [CoordW-1:0]  query_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  output logic               done_o,
  output logic               inside_res_o,
  output logic [1:0]         outcome_o
);

  tri_t        tri_q;
  logic        prep_valid, mul_valid;
  prep_t       prep;
  prod_stage_t prod;
  outcome_e    outcome;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_A_X: tri_q.ax <= cfg_data_i;
        REG_A_Y: tri_q.ay <= cfg_data_i;
        REG_B_X: tri_q.bx <= cfg_data_i;
        REG_B_Y: tri_q.by <= cfg_data_i;
        REG_C_X: tri_q.cx <= cfg_data_i;
        REG_C_Y: tri_q.cy <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptt_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .tri_i     (tri_q),
    .query_x_i (coord_t'(query_x_i)),
    .query_y_i (coord_t'(query_y_i)),
    .valid_o   (prep_valid),
    .prep_o    (prep)
  );

  ptt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (mul_valid),
    .prod_o  (prod)
  );

  ptt_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (mul_valid),
    .prod_i    (prod),
    .valid_o   (done_o),
    .inside_o  (inside_res_o),
    .outcome_o (outcome)
  );

  assign outcome_o = outcome;

endmodule

// ===== rtl/core/ptt_checker.sv =====
`timescale 1ns / 1ps

module ptt_checker import ptt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       inside_res_o,
  input logic [1:0] outcome_o
);

  // every accepted beat comes back as a result on done_o
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("accepted query produced no result");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without matching query");

  a_inside_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inside_res_o) |-> (outcome_o == OUT_INSIDE))
    else $error("inside flag with non-inside outcome");

  a_code_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (outcome_o == OUT_INSIDE)) |-> inside_res_o)
    else $error("inside outcome without inside flag");

endmodule

bind point_in_triangle_test ptt_checker u_ptt_checker (.*);
